### rtl/core/wrop_pkg.sv
// Package for the wrapped rectangle operation unit.
// Holds coordinate widths, action codes, payload structs and helpers.
// No dependencies.
`timescale 1ns / 1ps

package wrop_pkg;

  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned WW_BITS    = 14;
  // internal width: coordinate plus or minus world width, with headroom
  localparam int unsigned EXT_BITS   = ((COORD_BITS > WW_BITS) ? COORD_BITS : WW_BITS) + 2;

  localparam logic [WW_BITS-1:0] WW_RESET = WW_BITS'(8192);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [EXT_BITS-1:0]   ext_t;
  typedef logic [WW_BITS-1:0]           ww_t;

  typedef enum logic [1:0] {
    ACT_OVERLAP   = 2'd0,
    ACT_INTERSECT = 2'd1,
    ACT_UNION     = 2'd2
  } action_e;

  localparam ext_t COORD_MAX_X = ext_t'($signed({1'b0, {(COORD_BITS-1){1'b1}}}));
  localparam ext_t COORD_MIN_X = ext_t'($signed({1'b1, {(COORD_BITS-1){1'b0}}}));

  typedef struct packed {
    logic [1:0] action;
    coord_t     a_min_x;
    coord_t     a_max_x;
    coord_t     a_min_y;
    coord_t     a_max_y;
    coord_t     b_min_x;
    coord_t     b_max_x;
    coord_t     b_min_y;
    coord_t     b_max_y;
  } in_item_t;

  typedef struct packed {
    logic   hit;
    coord_t res_min_x;
    coord_t res_max_x;
    coord_t res_min_y;
    coord_t res_max_y;
    coord_t other_min_x;
    coord_t other_max_x;
  } out_item_t;

  function automatic ext_t smax(input ext_t a, input ext_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic ext_t smin(input ext_t a, input ext_t b);
    return (a < b) ? a : b;
  endfunction

  // clamp to the signed coordinate range
  function automatic coord_t sat(input ext_t v);
    coord_t r;
    if (v > COORD_MAX_X) begin
      r = COORD_MAX_X[COORD_BITS-1:0];
    end else if (v < COORD_MIN_X) begin
      r = COORD_MIN_X[COORD_BITS-1:0];
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/core/wrop_ifs.sv
// Valid/ready channel interfaces for the wrapped rectangle operation unit.
// Depends on wrop_pkg for the payload structs.
`timescale 1ns / 1ps

interface wrop_in_if;
  import wrop_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface wrop_out_if;
  import wrop_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/wrapped_rect_op_unit.sv
// Each input transfer is registered in the input reg, then in the result reg, before out_o.
// Throughput: one rectangle pair per cycle, sustained, while out_o is taken.
// The rate is set by the two-stage register pipeline (input reg, result reg).
// Reset (rst_ni low, async) empties both stages; world width returns to 8192.
// Depends on wrop_pkg and wrop_ifs.
`timescale 1ns / 1ps

module wrapped_rect_op_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  ww_we_i,
  input  logic [wrop_pkg::WW_BITS-1:0] ww_wdata_i,
  wrop_in_if.sink               in_i,
  wrop_out_if.source            out_o
);
  import wrop_pkg::*;

  // ---------------------------------------------------------------------
  // World width config: user writes only while idle; the unit does not check.
  // ---------------------------------------------------------------------
  ww_t ww_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ww_q <= WW_RESET;
    end else if (ww_we_i) begin
      ww_q <= ww_wdata_i;
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline control. Stage 1 holds the input item, stage 2 the result.
  // Each stage moves whenever the stage after it is free or draining; a waiting
  // result stops a new transfer into stage 1 only while stage 1 is full.
  // ---------------------------------------------------------------------
  logic     s1_valid_q;
  logic     out_valid_q;
  logic     s2_ready;
  logic     s1_ready;
  logic     in_fire;
  logic     s1_adv;
  in_item_t s1_q;
  out_item_t out_q;
  out_item_t res_d;

  assign s2_ready = !out_valid_q || out_o.ready;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign in_fire  = in_i.valid && s1_ready;
  assign s1_adv   = s1_valid_q && s2_ready;

  assign in_i.ready    = s1_ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s2_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= in_i.payload;
    end
    if (s1_adv) begin
      out_q <= res_d;
    end
  end

  // ---------------------------------------------------------------------
  // Datapath. Coordinates are widened so that max x +/- world width never
  // wraps; only union can push a value past the coordinate range, and the
  // final clamp saturates it.
  // ---------------------------------------------------------------------
  ext_t w;
  ext_t ax0, ax1, ay0, ay1, bx0, bx1, by0, by1;
  ext_t wp, wq;
  logic a_uw, b_uw;   // max x below world width: rectangle does not wrap
  logic y_hit;

  assign w   = ext_t'($signed({1'b0, ww_q}));
  assign ax0 = ext_t'(s1_q.a_min_x);
  assign ax1 = ext_t'(s1_q.a_max_x);
  assign ay0 = ext_t'(s1_q.a_min_y);
  assign ay1 = ext_t'(s1_q.a_max_y);
  assign bx0 = ext_t'(s1_q.b_min_x);
  assign bx1 = ext_t'(s1_q.b_max_x);
  assign by0 = ext_t'(s1_q.b_min_y);
  assign by1 = ext_t'(s1_q.b_max_y);

  assign wp    = ax1 - w;
  assign wq    = bx1 - w;
  assign a_uw  = ax1 < w;
  assign b_uw  = bx1 < w;
  assign y_hit = !((by0 >= ay1) || (ay0 >= by1));

  // overlap test
  logic ovl_hit;

  always_comb begin
    if (!y_hit) begin
      ovl_hit = 1'b0;
    end else if (a_uw) begin
      if (b_uw) begin
        ovl_hit = (bx1 > ax0) && (ax1 > bx0);
      end else begin
        ovl_hit = (ax0 < wq) || (ax1 > bx0);
      end
    end else begin
      if (!b_uw) begin
        ovl_hit = 1'b1;
      end else begin
        ovl_hit = (bx0 < wp) || (bx1 > ax0);
      end
    end
  end

  // intersect: clipped x spans for both rectangles; the y span is clipped in the result select
  logic isect_hit;
  logic x_hit;
  ext_t ip_x0, ip_x1, iq_x0, iq_x1;

  always_comb begin
    ip_x0 = ax0;
    ip_x1 = ax1;
    iq_x0 = bx0;
    iq_x1 = bx1;
    x_hit = 1'b1;
    if (a_uw && b_uw) begin
      x_hit = !((bx1 <= ax0) || (ax1 <= bx0));
      ip_x0 = smax(ax0, bx0);
      ip_x1 = smin(ax1, bx1);
    end else if (a_uw) begin
      // second wraps: the clip lands in the second rectangle's span
      if ((ax0 < wq) && (ax1 <= bx0)) begin
        iq_x0 = ax0;
        iq_x1 = smin(ax1, wq);
      end else begin
        x_hit = ax1 > bx0;
        iq_x1 = ax1;
        iq_x0 = smax(bx0, ax0);
      end
    end else if (b_uw) begin
      if ((bx0 < wp) && (bx1 <= ax0)) begin
        ip_x0 = bx0;
        ip_x1 = smin(bx1, wp);
      end else begin
        x_hit = bx1 > ax0;
        ip_x1 = bx1;
        ip_x0 = smax(ax0, bx0);
      end
    end else begin
      ip_x0 = smax(ax0, bx0);
      ip_x1 = smin(ax1, bx1);
    end
    isect_hit = y_hit && x_hit;
  end

  // union: enclosing rectangle
  ext_t un_x0, un_x1;

  always_comb begin
    un_x0 = smin(ax0, bx0);
    un_x1 = smax(ax1, bx1);
    if (a_uw && !b_uw) begin
      if (ax1 <= bx0) begin
        un_x0 = bx0;
        un_x1 = smax(ax1 + w, bx1);
      end else begin
        un_x1 = bx1;
      end
    end else if (!a_uw && b_uw) begin
      if (bx1 <= ax0) begin
        un_x0 = ax0;
        un_x1 = smax(ax1, bx1 + w);
      end else begin
        un_x1 = ax1;
      end
    end
  end

  // result select; anything that is not changed passes the inputs through
  always_comb begin
    res_d.hit         = 1'b0;
    res_d.res_min_x   = s1_q.a_min_x;
    res_d.res_max_x   = s1_q.a_max_x;
    res_d.res_min_y   = s1_q.a_min_y;
    res_d.res_max_y   = s1_q.a_max_y;
    res_d.other_min_x = s1_q.b_min_x;
    res_d.other_max_x = s1_q.b_max_x;
    case (s1_q.action)
      ACT_OVERLAP: begin
        res_d.hit = ovl_hit;
      end
      ACT_INTERSECT: begin
        res_d.hit = isect_hit;
        if (isect_hit) begin
          res_d.res_min_x   = sat(ip_x0);
          res_d.res_max_x   = sat(ip_x1);
          res_d.res_min_y   = sat(smax(ay0, by0));
          res_d.res_max_y   = sat(smin(ay1, by1));
          res_d.other_min_x = sat(iq_x0);
          res_d.other_max_x = sat(iq_x1);
        end
      end
      ACT_UNION: begin
        res_d.hit       = 1'b1;
        res_d.res_min_x = sat(un_x0);
        res_d.res_max_x = sat(un_x1);
        res_d.res_min_y = sat(smin(ay0, by0));
        res_d.res_max_y = sat(smax(ay1, by1));
      end
      default: begin
        res_d.hit = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // intersect and overlap must agree on whether the rectangles meet
  a_isect_matches_ovl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (isect_hit == ovl_hit))
    else $error("intersect hit differs from overlap hit");

  // a union item always comes out with hit set
  a_union_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && (s1_q.action == ACT_UNION)) |=> (out_valid_q && out_q.hit))
    else $error("union result without hit");

  // a missed intersect passes its input fields through with hit low
  a_isect_miss_passthru: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && (s1_q.action == ACT_INTERSECT) && !ovl_hit) |=>
      (!out_q.hit && (out_q.res_min_x == $past(s1_q.a_min_x))
       && (out_q.other_max_x == $past(s1_q.b_max_x))))
    else $error("missed intersect changed its inputs");

  // an item leaving stage 1 always lands in the result register
  a_s1_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("item dropped between stages");

endmodule

### test/wrapped_rect_op_unit_tb.sv
// Self-checking testbench for wrapped_rect_op_unit: overlap, intersect and union of
// rectangle pairs on a horizontally wrapping world, checked against an in-bench predictor.
// Depends on wrop_pkg, wrop_ifs and the unit itself.
`timescale 1ns / 1ps

module wrapped_rect_op_unit_tb;
  import wrop_pkg::*;

  // action code 3 has no operation; the unit must pass the inputs through with hit low
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int COORD_HI       = 2 ** (COORD_BITS - 1) - 1;
  localparam int COORD_LO       = -(2 ** (COORD_BITS - 1));
  // cycles without any transfer on either channel before the run is declared hung
  localparam int WATCHDOG_LIMIT = 1000;

  // clock, reset and register port; all known from time zero
  logic clk_i      = 1'b0;
  logic rst_ni     = 1'b0;
  logic ww_we_i    = 1'b0;
  ww_t  ww_wdata_i = WW_RESET;

  // bench-side copies of what we drive onto the channels
  logic     in_valid   = 1'b0;
  in_item_t in_payload = '0;
  logic     out_ready  = 1'b0;

  wrop_in_if  in_bus ();
  wrop_out_if out_bus ();

  assign in_bus.valid   = in_valid;
  assign in_bus.payload = in_payload;
  assign out_bus.ready  = out_ready;

  wrapped_rect_op_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ww_we_i    (ww_we_i),
    .ww_wdata_i (ww_wdata_i),
    .in_i       (in_bus),
    .out_o      (out_bus)
  );

  // rectangle pairs waiting to be sent, and the results they must produce, oldest first
  in_item_t  pending_pairs[$];
  out_item_t predicted_results[$];

  // world width as the unit should currently hold it; only changes while the unit is idle
  ww_t world_width_model = WW_RESET;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int results_seen   = 0;
  int quiet_cycles   = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  function automatic int imin(input int a, input int b);
    return (a < b) ? a : b;
  endfunction

  // saturate to the signed coordinate range
  function automatic coord_t to_coord(input int v);
    if (v > COORD_HI) begin
      return coord_t'(COORD_HI);
    end
    if (v < COORD_LO) begin
      return coord_t'(COORD_LO);
    end
    return coord_t'(v);
  endfunction

  // Expected result for one rectangle pair at world width w.
  // A rectangle with max x >= w is wrapped: it runs on from the right edge
  // and continues from x = 0 up to max x - w.
  function automatic out_item_t predict_rect_op(input in_item_t it, input int w);
    int        ax0, ax1, ay0, ay1, bx0, bx1, by0, by1;
    int        rx0, rx1, ry0, ry1, ox0, ox1;
    int        nx0, nx1, mx0, mx1;
    logic      hit;
    logic      y_apart;
    out_item_t r;
    ax0 = it.a_min_x; ax1 = it.a_max_x; ay0 = it.a_min_y; ay1 = it.a_max_y;
    bx0 = it.b_min_x; bx1 = it.b_max_x; by0 = it.b_min_y; by1 = it.b_max_y;
    rx0 = ax0; rx1 = ax1; ry0 = ay0; ry1 = ay1;
    ox0 = bx0; ox1 = bx1;
    hit = 1'b0;
    y_apart = (by0 >= ay1) || (ay0 >= by1);
    case (it.action)
      ACT_OVERLAP: begin
        if (y_apart) begin
          hit = 1'b0;
        end else if (ax1 < w) begin
          if (bx1 < w) begin
            hit = (bx1 > ax0) && (ax1 > bx0);
          end else begin
            hit = (ax0 < bx1 - w) || (ax1 > bx0);
          end
        end else if (bx1 >= w) begin
          hit = 1'b1;
        end else begin
          hit = (bx0 < ax1 - w) || (bx1 > ax0);
        end
      end
      ACT_INTERSECT: begin
        hit = !y_apart;
        nx0 = ax0; nx1 = ax1; mx0 = bx0; mx1 = bx1;
        if (hit) begin
          if (ax1 < w) begin
            if (bx1 < w) begin
              if (bx1 <= ax0 || ax1 <= bx0) begin
                hit = 1'b0;
              end else begin
                nx0 = imax(ax0, bx0);
                nx1 = imin(ax1, bx1);
              end
            end else if (ax0 < bx1 - w && ax1 <= bx0) begin
              // clipped span lands in the second rectangle's x fields
              mx0 = ax0;
              mx1 = imin(ax1, bx1 - w);
            end else if (ax1 <= bx0) begin
              hit = 1'b0;
            end else begin
              mx1 = ax1;
              mx0 = imax(bx0, ax0);
            end
          end else begin
            if (bx1 < w) begin
              if (bx0 < ax1 - w && bx1 <= ax0) begin
                nx0 = bx0;
                nx1 = imin(bx1, ax1 - w);
              end else if (bx1 <= ax0) begin
                hit = 1'b0;
              end else begin
                nx1 = bx1;
                nx0 = imax(ax0, bx0);
              end
            end else begin
              nx0 = imax(ax0, bx0);
              nx1 = imin(ax1, bx1);
            end
          end
        end
        // a miss leaves every field as it came in
        if (hit) begin
          rx0 = nx0; rx1 = nx1; ox0 = mx0; ox1 = mx1;
          ry0 = imax(ay0, by0);
          ry1 = imin(ay1, by1);
        end
      end
      ACT_UNION: begin
        hit = 1'b1;
        ry0 = imin(ay0, by0);
        ry1 = imax(ay1, by1);
        if (ax1 < w && bx1 >= w) begin
          if (ax1 <= bx0) begin
            rx0 = bx0;
            rx1 = imax(ax1 + w, bx1);
          end else begin
            rx1 = bx1;
            rx0 = imin(ax0, bx0);
          end
        end else if (ax1 >= w && bx1 < w) begin
          if (bx1 <= ax0) begin
            rx1 = imax(ax1, bx1 + w);
          end else begin
            rx0 = imin(ax0, bx0);
          end
        end else begin
          rx0 = imin(ax0, bx0);
          rx1 = imax(ax1, bx1);
        end
      end
      default: begin
        hit = 1'b0;
      end
    endcase
    r.hit         = hit;
    r.res_min_x   = to_coord(rx0);
    r.res_max_x   = to_coord(rx1);
    r.res_min_y   = to_coord(ry0);
    r.res_max_y   = to_coord(ry1);
    r.other_min_x = to_coord(ox0);
    r.other_max_x = to_coord(ox1);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 50) begin
      $display("[%0t] mismatch on result %0d: %s", $time, results_seen, msg);
    end
  endtask

  task automatic check_result(input out_item_t got, input out_item_t want);
    if (got.hit !== want.hit)
      report_mismatch($sformatf("hit %0d, want %0d", got.hit, want.hit));
    if (got.res_min_x !== want.res_min_x)
      report_mismatch($sformatf("res_min_x %0d, want %0d", got.res_min_x, want.res_min_x));
    if (got.res_max_x !== want.res_max_x)
      report_mismatch($sformatf("res_max_x %0d, want %0d", got.res_max_x, want.res_max_x));
    if (got.res_min_y !== want.res_min_y)
      report_mismatch($sformatf("res_min_y %0d, want %0d", got.res_min_y, want.res_min_y));
    if (got.res_max_y !== want.res_max_y)
      report_mismatch($sformatf("res_max_y %0d, want %0d", got.res_max_y, want.res_max_y));
    if (got.other_min_x !== want.other_min_x)
      report_mismatch($sformatf("other_min_x %0d, want %0d", got.other_min_x,
                                want.other_min_x));
    if (got.other_max_x !== want.other_max_x)
      report_mismatch($sformatf("other_max_x %0d, want %0d", got.other_max_x,
                                want.other_max_x));
  endtask

  // Driver: present the next pair when the channel is free, idling at random.
  // A pair is predicted at the edge where its transfer happens.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_bus.ready) begin
        predicted_results.push_back(predict_rect_op(in_payload, world_width_model));
      end
      if (!in_valid || in_bus.ready) begin
        if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid   <= 1'b1;
          in_payload <= pending_pairs.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: take results with random back-pressure and check each against the
  // oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_ready) begin
        results_seen++;
        if (predicted_results.size() == 0) begin
          report_mismatch("result with nothing pending");
        end else begin
          check_result(out_bus.payload, predicted_results.pop_front());
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_bus.ready) || (out_bus.valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("** wrapped_rect_op_unit: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Checked at the falling edge so all rising-edge updates have settled.
  // The extra cycles cover the two-stage pipeline.
  task automatic wait_until_drained();
    do begin
      @(negedge clk_i);
    end while (pending_pairs.size() != 0 || in_valid || predicted_results.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_world_width(input ww_t value);
    @(posedge clk_i);
    ww_we_i    <= 1'b1;
    ww_wdata_i <= value;
    @(posedge clk_i);
    ww_we_i           <= 1'b0;
    world_width_model = value;
    @(negedge clk_i);
  endtask

  function automatic void push_pair(input logic [1:0] act, input int ax0, input int ax1,
                                    input int ay0, input int ay1, input int bx0,
                                    input int bx1, input int by0, input int by1);
    in_item_t it;
    it.action  = act;
    it.a_min_x = to_coord(ax0); it.a_max_x = to_coord(ax1);
    it.a_min_y = to_coord(ay0); it.a_max_y = to_coord(ay1);
    it.b_min_x = to_coord(bx0); it.b_max_x = to_coord(bx1);
    it.b_min_y = to_coord(by0); it.b_max_y = to_coord(by1);
    pending_pairs.push_back(it);
  endfunction

  // x span starting inside the world (near zero for width zero); long spans run past the edge and wrap
  function automatic void pick_x_span(input int w, output coord_t lo, output coord_t hi);
    int base;
    int span;
    if (w > 0) begin
      base = $urandom_range(w - 1);
    end else begin
      base = $urandom_range(64);
      base = base - 32;
    end
    case ($urandom_range(3))
      0:       span = $urandom_range(7) + 1;
      1:       span = $urandom_range(w / 4 + 1) + 1;
      2:       span = w - base;            // max x lands exactly on the wrap point
      default: span = $urandom_range(w + 16);
    endcase
    lo = to_coord(base);
    hi = to_coord(base + span);
  endfunction

  function automatic void pick_y_span(output coord_t lo, output coord_t hi);
    int base;
    int span;
    base = $urandom_range(300);
    base = base - 150;
    span = $urandom_range(120);
    lo = to_coord(base);
    hi = to_coord(base + span);
  endfunction

  // One configuration phase: new width, new idle mix, random pairs.
  // Halfway through, the sender holds back until every result is in.
  task automatic run_phase(input ww_t width, input int sidle, input int rstall,
                           input int count);
    in_item_t it;
    int       w;
    int       off;
    int       n;
    wait_until_drained();
    write_world_width(width);
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    w = width;
    for (n = 0; n < count; n++) begin
      if (n == count / 2) begin
        wait_until_drained();
      end
      if ($urandom_range(99) < 15) begin
        // raw noise over the full field ranges, unused action included
        it.action  = 2'($urandom);
        it.a_min_x = coord_t'($urandom); it.a_max_x = coord_t'($urandom);
        it.a_min_y = coord_t'($urandom); it.a_max_y = coord_t'($urandom);
        it.b_min_x = coord_t'($urandom); it.b_max_x = coord_t'($urandom);
        it.b_min_y = coord_t'($urandom); it.b_max_y = coord_t'($urandom);
      end else begin
        it.action = ($urandom_range(19) == 0) ? ACT_UNUSED : 2'($urandom_range(2));
        pick_x_span(w, it.a_min_x, it.a_max_x);
        pick_y_span(it.a_min_y, it.a_max_y);
        if ($urandom_range(3) == 0) begin
          // second rectangle close to the first so edges nearly touch
          off = $urandom_range(40);
          it.b_min_x = to_coord(int'(it.a_min_x) + off - 20);
          off = $urandom_range(40);
          it.b_max_x = to_coord(int'(it.a_max_x) + off - 20);
          off = $urandom_range(20);
          it.b_min_y = to_coord(int'(it.a_min_y) + off - 10);
          off = $urandom_range(20);
          it.b_max_y = to_coord(int'(it.a_max_y) + off - 10);
        end else begin
          pick_x_span(w, it.b_min_x, it.b_max_x);
          pick_y_span(it.b_min_y, it.b_max_y);
        end
      end
      pending_pairs.push_back(it);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed pairs at the reset width of 8192; max x >= 8192 means wrapped.
    push_pair(ACT_OVERLAP,   0, 100, 0, 100,   50, 150, 50, 150);
    push_pair(ACT_OVERLAP,   0, 100, 0, 100,   50, 150, 100, 200);  // y spans only touch
    push_pair(ACT_OVERLAP,   0, 50, 0, 10,     8000, 8200, 0, 10);  // hit via wrap tail
    push_pair(ACT_OVERLAP,   10, 50, 0, 10,    8000, 8200, 0, 10);  // tail too short
    push_pair(ACT_OVERLAP,   8000, 8300, 0, 10, 0, 50, 0, 10);
    push_pair(ACT_OVERLAP,   8000, 8300, 0, 10, 8100, 8400, 0, 10);
    push_pair(ACT_INTERSECT, 0, 100, 0, 100,   50, 150, 50, 150);
    push_pair(ACT_INTERSECT, 0, 100, 0, 100,   100, 150, 0, 100);   // x spans only touch
    // first unwrapped, second wrapped: clipped span goes to the other_* fields
    push_pair(ACT_INTERSECT, 0, 50, 0, 10,     8000, 8200, 5, 20);
    push_pair(ACT_INTERSECT, 7000, 8100, 0, 10, 8000, 8300, 0, 10);
    push_pair(ACT_INTERSECT, 100, 200, 0, 10,  8000, 8200, 0, 10);  // miss, fields pass
    push_pair(ACT_INTERSECT, 8000, 8200, 0, 10, 0, 50, 0, 10);
    push_pair(ACT_INTERSECT, 8000, 8300, 0, 10, 7000, 8100, 0, 10);
    push_pair(ACT_INTERSECT, 8000, 8300, 0, 10, 8100, 8500, -5, 5);
    push_pair(ACT_UNION,     0, 100, 0, 100,   50, 150, 50, 150);
    push_pair(ACT_UNION,     0, 100, 0, 10,    8000, 8300, 5, 20);
    push_pair(ACT_UNION,     7000, 8100, 0, 10, 8000, 8300, 0, 10);
    push_pair(ACT_UNION,     8000, 8300, 0, 10, 100, 200, 0, 10);
    push_pair(ACT_UNION,     8000, 8300, 0, 10, 7000, 8100, 0, 10);
    push_pair(ACT_UNION,     8000, 8300, 0, 10, 8100, 8500, 0, 10);
    push_pair(ACT_UNUSED,    1, 2, 3, 4,       5, 6, 7, 8);
    // coordinate extremes, inverted and empty rectangles
    push_pair(ACT_OVERLAP,   COORD_LO, COORD_HI, COORD_LO, COORD_HI,
                             COORD_LO, COORD_HI, COORD_LO, COORD_HI);
    push_pair(ACT_INTERSECT, COORD_HI, COORD_LO, COORD_HI, COORD_LO,
                             COORD_LO, COORD_HI, COORD_LO, COORD_HI);
    push_pair(ACT_UNION,     COORD_LO, COORD_HI, COORD_LO, COORD_HI,
                             COORD_HI, COORD_HI, COORD_LO, COORD_LO);
    push_pair(ACT_INTERSECT, 5, 5, 0, 10,      5, 5, 0, 10);

    // Random phases over width extremes (zero included) and all idle mixes.
    run_phase(ww_t'(16383), 0, 0, 190);
    run_phase(ww_t'(1), 47, 0, 190);
    run_phase(ww_t'(0), 0, 47, 190);
    run_phase(ww_t'($urandom_range(16382, 2)), 29, 29, 190);
    run_phase(ww_t'(100), 0, 47, 190);
    run_phase(ww_t'($urandom_range(16382, 2)), 29, 29, 190);

    wait_until_drained();
    if (mismatch_count == 0) begin
      $display("** wrapped_rect_op_unit: PASSED **");
    end else begin
      $display("** wrapped_rect_op_unit: FAILED **");
    end
    $finish;
  end

endmodule
